### rtl/swkft_pkg.sv
// Shared types for the sliding window key frequency tracker.
// Opcodes, sequencer states and the control/status bundles between top and table store.
`default_nettype none
package swkft_pkg;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_EP_QUERY = 2'd1,
        OP_FP_QUERY = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_OLD_RD,
        S_OLD_LD,
        S_SCAN,
        S_WB,
        S_RESP
    } state_t;

    typedef struct packed {
        logic clear;
        logic scan_init;
        logic rd_en;
        logic wb_retire;
        logic wb_add;
    } tbl_cmd_t;

    typedef struct packed {
        logic print_hit;
        logic peer_hit;
    } tbl_stat_t;

endpackage
`default_nettype wire

### rtl/swkft_tables.sv
// Fingerprint, endpoint and pair tables: three synchronous memories, linear scan
// match capture and the read-modify-write back. Depends on swkft_pkg.
`default_nettype none
module swkft_tables #(
    parameter int CAPACITY = 256,
    parameter int AW = 8,
    parameter int CW = 9
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire swkft_pkg::tbl_cmd_t cmd,
    input  wire logic [AW-1:0]       addr,
    input  wire logic [63:0]         ep_key,
    input  wire logic [63:0]         fp_key,
    output swkft_pkg::tbl_stat_t     stat,
    output logic [CW-1:0]            peer_total,
    output logic [CW-1:0]            peer_unique,
    output logic [63:0]              peer_last,
    output logic [CW-1:0]            print_tally
);

    localparam int PR_W = 1 + 64 + CW;
    localparam int PE_W = 1 + 64 + 2 * CW + 64;
    localparam int PA_W = 1 + 128 + CW;

    logic [PR_W-1:0] pr_mem [CAPACITY];
    logic [PE_W-1:0] pe_mem [CAPACITY];
    logic [PA_W-1:0] pa_mem [CAPACITY];

    logic [PR_W-1:0] pr_q_reg;
    logic [PE_W-1:0] pe_q_reg;
    logic [PA_W-1:0] pa_q_reg;
    logic            rd_vld_reg;
    logic [AW-1:0]   rd_idx_reg;

    logic            pr_we, pe_we, pa_we;
    logic [AW-1:0]   pr_waddr, pe_waddr, pa_waddr;
    logic [PR_W-1:0] pr_wdata;
    logic [PE_W-1:0] pe_wdata;
    logic [PA_W-1:0] pa_wdata;

    // scan capture
    logic            pr_hit_reg, pr_free_reg;
    logic [AW-1:0]   pr_idx_reg, pr_fidx_reg;
    logic [CW-1:0]   pr_tally_reg;
    logic            pe_hit_reg, pe_free_reg;
    logic [AW-1:0]   pe_idx_reg, pe_fidx_reg;
    logic [CW-1:0]   pe_total_reg, pe_unique_reg;
    logic [63:0]     pe_last_reg;
    logic            pa_hit_reg, pa_free_reg;
    logic [AW-1:0]   pa_idx_reg, pa_fidx_reg;
    logic [CW-1:0]   pa_tally_reg;

    logic            pr_match, pr_empty, pe_match, pe_empty, pa_match, pa_empty;
    logic            new_pair;
    logic [CW-1:0]   tot, uni;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            pr_q_reg <= pr_mem[addr];
            pe_q_reg <= pe_mem[addr];
            pa_q_reg <= pa_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pr_we)
            pr_mem[pr_waddr] <= pr_wdata;
        if (pe_we)
            pe_mem[pe_waddr] <= pe_wdata;
        if (pa_we)
            pa_mem[pa_waddr] <= pa_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            rd_idx_reg <= '0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
            rd_idx_reg <= addr;
        end
    end

    assign pr_match = rd_vld_reg && pr_q_reg[PR_W-1] && (pr_q_reg[CW +: 64] == fp_key);
    assign pr_empty = rd_vld_reg && !pr_q_reg[PR_W-1];
    assign pe_match = rd_vld_reg && pe_q_reg[PE_W-1] && (pe_q_reg[64 + 2 * CW +: 64] == ep_key);
    assign pe_empty = rd_vld_reg && !pe_q_reg[PE_W-1];
    assign pa_match = rd_vld_reg && pa_q_reg[PA_W-1] && (pa_q_reg[CW + 64 +: 64] == ep_key)
                      && (pa_q_reg[CW +: 64] == fp_key);
    assign pa_empty = rd_vld_reg && !pa_q_reg[PA_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_hit_reg  <= 1'b0;
            pr_free_reg <= 1'b0;
            pe_hit_reg  <= 1'b0;
            pe_free_reg <= 1'b0;
            pa_hit_reg  <= 1'b0;
            pa_free_reg <= 1'b0;
        end
        else if (cmd.scan_init)
        begin
            pr_hit_reg  <= 1'b0;
            pr_free_reg <= 1'b0;
            pe_hit_reg  <= 1'b0;
            pe_free_reg <= 1'b0;
            pa_hit_reg  <= 1'b0;
            pa_free_reg <= 1'b0;
        end
        else
        begin
            if (pr_match)
                pr_hit_reg <= 1'b1;
            if (pr_empty)
                pr_free_reg <= 1'b1;
            if (pe_match)
                pe_hit_reg <= 1'b1;
            if (pe_empty)
                pe_free_reg <= 1'b1;
            if (pa_match)
                pa_hit_reg <= 1'b1;
            if (pa_empty)
                pa_free_reg <= 1'b1;
        end
    end

    // keep the first hit and the first free slot of each table
    always_ff @(posedge clk)
    begin
        if (pr_match && !pr_hit_reg)
        begin
            pr_idx_reg   <= rd_idx_reg;
            pr_tally_reg <= pr_q_reg[CW-1:0];
        end
        if (pr_empty && !pr_free_reg)
            pr_fidx_reg <= rd_idx_reg;
        if (pe_match && !pe_hit_reg)
        begin
            pe_idx_reg    <= rd_idx_reg;
            pe_total_reg  <= pe_q_reg[64 + CW +: CW];
            pe_unique_reg <= pe_q_reg[64 +: CW];
            pe_last_reg   <= pe_q_reg[63:0];
        end
        if (pe_empty && !pe_free_reg)
            pe_fidx_reg <= rd_idx_reg;
        if (pa_match && !pa_hit_reg)
        begin
            pa_idx_reg   <= rd_idx_reg;
            pa_tally_reg <= pa_q_reg[CW-1:0];
        end
        if (pa_empty && !pa_free_reg)
            pa_fidx_reg <= rd_idx_reg;
    end

    assign new_pair = !pa_hit_reg && pa_free_reg;

    always_comb
    begin
        pr_we    = 1'b0;
        pe_we    = 1'b0;
        pa_we    = 1'b0;
        pr_waddr = addr;
        pe_waddr = addr;
        pa_waddr = addr;
        pr_wdata = '0;
        pe_wdata = '0;
        pa_wdata = '0;
        tot      = pe_total_reg;
        uni      = pe_unique_reg;
        if (cmd.clear)
        begin
            pr_we = 1'b1;
            pe_we = 1'b1;
            pa_we = 1'b1;
        end
        else if (cmd.wb_retire)
        begin
            if (pr_hit_reg)
            begin
                pr_we    = 1'b1;
                pr_waddr = pr_idx_reg;
                if (pr_tally_reg > CW'(1))
                    pr_wdata = {1'b1, fp_key, pr_tally_reg - CW'(1)};
                else
                    pr_wdata = {1'b0, fp_key, pr_tally_reg};
            end
            if (pe_hit_reg)
            begin
                if (pe_total_reg != '0)
                    tot = pe_total_reg - CW'(1);
                if (pa_hit_reg)
                begin
                    pa_we    = 1'b1;
                    pa_waddr = pa_idx_reg;
                    if (pa_tally_reg > CW'(1))
                        pa_wdata = {1'b1, ep_key, fp_key, pa_tally_reg - CW'(1)};
                    else
                    begin
                        pa_wdata = {1'b0, ep_key, fp_key, pa_tally_reg};
                        if (pe_unique_reg != '0)
                            uni = pe_unique_reg - CW'(1);
                    end
                end
                pe_we    = 1'b1;
                pe_waddr = pe_idx_reg;
                pe_wdata = {tot != '0, ep_key, tot, uni, pe_last_reg};
            end
        end
        else if (cmd.wb_add)
        begin
            if (pr_hit_reg)
            begin
                pr_we    = 1'b1;
                pr_waddr = pr_idx_reg;
                pr_wdata = {1'b1, fp_key, pr_tally_reg + CW'(1)};
            end
            else if (pr_free_reg)
            begin
                pr_we    = 1'b1;
                pr_waddr = pr_fidx_reg;
                pr_wdata = {1'b1, fp_key, CW'(1)};
            end
            if (pe_hit_reg || pe_free_reg)
            begin
                tot      = (pe_hit_reg ? pe_total_reg : '0) + CW'(1);
                uni      = (pe_hit_reg ? pe_unique_reg : '0) + CW'(new_pair);
                pe_we    = 1'b1;
                pe_waddr = pe_hit_reg ? pe_idx_reg : pe_fidx_reg;
                pe_wdata = {1'b1, ep_key, tot, uni, fp_key};
                if (pa_hit_reg)
                begin
                    pa_we    = 1'b1;
                    pa_waddr = pa_idx_reg;
                    pa_wdata = {1'b1, ep_key, fp_key, pa_tally_reg + CW'(1)};
                end
                else if (pa_free_reg)
                begin
                    pa_we    = 1'b1;
                    pa_waddr = pa_fidx_reg;
                    pa_wdata = {1'b1, ep_key, fp_key, CW'(1)};
                end
            end
        end
    end

    assign stat.print_hit = pr_hit_reg;
    assign stat.peer_hit  = pe_hit_reg;
    assign peer_total     = pe_total_reg;
    assign peer_unique    = pe_unique_reg;
    assign peer_last      = pe_last_reg;
    assign print_tally    = pr_tally_reg;

endmodule
`default_nettype wire

### rtl/sliding_window_key_frequency_tracker.sv
// Top level: sequencer, sample ring memory and occupancy counters.
// Depends on swkft_pkg and swkft_tables.
`default_nettype none
// A command is taken when start is high and busy is low; its single result shows
// for one cycle with done high and must be captured then, the receiver cannot stall.
// Every table lookup is a linear scan of the table memories, one entry per cycle
// through one read port, so timing follows CAPACITY. A query scans and then
// responds; an add into a window that is not full scans and writes back; an add
// into a full window first reads the oldest sample and retires it with its own
// scan and write-back, then scans and writes back the new sample; a clear sweeps
// every entry; an add with a zero key or fingerprint responds without a scan.
// Busy drops in the cycle after done, and the next command can be taken then.
// After reset the tables are swept clear with busy high before the first command.
module sliding_window_key_frequency_tracker #(
    parameter int CAPACITY = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [63:0] endpoint_key,
    input  wire logic [63:0] fingerprint,
    output logic             done,
    output logic             found,
    output logic [8:0]       endpoint_total,
    output logic [8:0]       endpoint_unique,
    output logic [63:0]      last_fingerprint,
    output logic [8:0]       fingerprint_tally,
    output logic [8:0]       occupancy
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = AW + 2;

    swkft_pkg::state_t state_reg, state_next;
    swkft_pkg::op_t    op_reg, op_next;
    logic [AW:0]       cnt_reg, cnt_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic              retire_reg, retire_next;
    logic              clr_resp_reg, clr_resp_next;
    logic [63:0]       in_ep_reg, in_ep_next;
    logic [63:0]       in_fp_reg, in_fp_next;
    logic [63:0]       key_ep_reg, key_ep_next;
    logic [63:0]       key_fp_reg, key_fp_next;

    logic [127:0]      win_mem [CAPACITY];
    logic [127:0]      win_q_reg;
    logic              win_re, win_we;
    logic [AW-1:0]     tail;
    logic [SW-1:0]     tail_sum;
    logic              scan_last;

    swkft_pkg::tbl_cmd_t  cmd;
    swkft_pkg::tbl_stat_t stat;
    logic [CW-1:0]        peer_total, peer_unique, print_tally;
    logic [63:0]          peer_last;

    swkft_tables #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_tables (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .addr        (cnt_reg[AW-1:0]),
        .ep_key      (key_ep_reg),
        .fp_key      (key_fp_reg),
        .stat        (stat),
        .peer_total  (peer_total),
        .peer_unique (peer_unique),
        .peer_last   (peer_last),
        .print_tally (print_tally)
    );

    assign tail_sum  = SW'(head_reg) + SW'(fill_reg);
    assign tail      = (tail_sum >= SW'(CAPACITY)) ? AW'(tail_sum - SW'(CAPACITY))
                                                   : AW'(tail_sum);
    assign scan_last = (cnt_reg == (AW+1)'(CAPACITY));

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        cnt_next      = cnt_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        retire_next   = retire_reg;
        clr_resp_next = clr_resp_reg;
        in_ep_next    = in_ep_reg;
        in_fp_next    = in_fp_reg;
        key_ep_next   = key_ep_reg;
        key_fp_next   = key_fp_reg;
        case (state_reg)
            swkft_pkg::S_CLR:
            begin
                cnt_next = cnt_reg + (AW+1)'(1);
                if (cnt_reg == (AW+1)'(CAPACITY - 1))
                begin
                    cnt_next   = '0;
                    head_next  = '0;
                    fill_next  = '0;
                    state_next = clr_resp_reg ? swkft_pkg::S_RESP : swkft_pkg::S_IDLE;
                end
            end
            swkft_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next     = swkft_pkg::op_t'(opcode);
                    in_ep_next  = endpoint_key;
                    in_fp_next  = fingerprint;
                    key_ep_next = endpoint_key;
                    key_fp_next = fingerprint;
                    retire_next = 1'b0;
                    cnt_next    = '0;
                    case (swkft_pkg::op_t'(opcode))
                        swkft_pkg::OP_CLEAR:
                        begin
                            clr_resp_next = 1'b1;
                            state_next    = swkft_pkg::S_CLR;
                        end
                        swkft_pkg::OP_ADD:
                        begin
                            if (endpoint_key == '0 || fingerprint == '0)
                                state_next = swkft_pkg::S_RESP;
                            else if (fill_reg == CW'(CAPACITY))
                                state_next = swkft_pkg::S_OLD_RD;
                            else
                                state_next = swkft_pkg::S_SCAN;
                        end
                        default:
                            state_next = swkft_pkg::S_SCAN;
                    endcase
                end
            end
            swkft_pkg::S_OLD_RD:
                state_next = swkft_pkg::S_OLD_LD;
            swkft_pkg::S_OLD_LD:
            begin
                key_ep_next = win_q_reg[127:64];
                key_fp_next = win_q_reg[63:0];
                retire_next = 1'b1;
                state_next  = swkft_pkg::S_SCAN;
            end
            swkft_pkg::S_SCAN:
            begin
                cnt_next = cnt_reg + (AW+1)'(1);
                if (scan_last)
                begin
                    cnt_next = '0;
                    if (op_reg == swkft_pkg::OP_ADD)
                        state_next = swkft_pkg::S_WB;
                    else
                        state_next = swkft_pkg::S_RESP;
                end
            end
            swkft_pkg::S_WB:
            begin
                if (retire_reg)
                begin
                    head_next   = (head_reg == AW'(CAPACITY - 1)) ? '0 : head_reg + AW'(1);
                    fill_next   = fill_reg - CW'(1);
                    retire_next = 1'b0;
                    key_ep_next = in_ep_reg;
                    key_fp_next = in_fp_reg;
                    state_next  = swkft_pkg::S_SCAN;
                end
                else
                begin
                    fill_next  = fill_reg + CW'(1);
                    state_next = swkft_pkg::S_RESP;
                end
            end
            swkft_pkg::S_RESP:
            begin
                clr_resp_next = 1'b0;
                state_next    = swkft_pkg::S_IDLE;
            end
            default:
                state_next = swkft_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.clear     = (state_reg == swkft_pkg::S_CLR);
        cmd.scan_init = (state_reg == swkft_pkg::S_SCAN) && (cnt_reg == '0);
        cmd.rd_en     = (state_reg == swkft_pkg::S_SCAN) && !scan_last;
        cmd.wb_retire = (state_reg == swkft_pkg::S_WB) && retire_reg;
        cmd.wb_add    = (state_reg == swkft_pkg::S_WB) && !retire_reg;
        win_re        = (state_reg == swkft_pkg::S_OLD_RD);
        win_we        = cmd.wb_add;
        busy          = (state_reg != swkft_pkg::S_IDLE);
        done          = (state_reg == swkft_pkg::S_RESP);
        found         = (op_reg == swkft_pkg::OP_EP_QUERY) && stat.peer_hit;
        endpoint_total    = found ? 9'(peer_total) : '0;
        endpoint_unique   = found ? 9'(peer_unique) : '0;
        last_fingerprint  = found ? peer_last : '0;
        fingerprint_tally = ((op_reg == swkft_pkg::OP_FP_QUERY) && stat.print_hit)
                            ? 9'(print_tally) : '0;
        occupancy         = 9'(fill_reg);
    end

    always_ff @(posedge clk)
    begin
        if (win_re)
            win_q_reg <= win_mem[head_reg];
        if (win_we)
            win_mem[tail] <= {in_ep_reg, in_fp_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= swkft_pkg::S_CLR;
            op_reg       <= swkft_pkg::OP_ADD;
            cnt_reg      <= '0;
            head_reg     <= '0;
            fill_reg     <= '0;
            retire_reg   <= 1'b0;
            clr_resp_reg <= 1'b0;
            in_ep_reg    <= '0;
            in_fp_reg    <= '0;
            key_ep_reg   <= '0;
            key_fp_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            cnt_reg      <= cnt_next;
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            retire_reg   <= retire_next;
            clr_resp_reg <= clr_resp_next;
            in_ep_reg    <= in_ep_next;
            in_fp_reg    <= in_fp_next;
            key_ep_reg   <= key_ep_next;
            key_fp_reg   <= key_fp_next;
        end
    end

endmodule
`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for sliding_window_key_frequency_tracker.
// Holds a scoreboard class with its own window/tally predictor; depends on swkft_pkg and the tracker top.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_DEPTH = 256;
    localparam int STALL_LIMIT = 6000;
    localparam int RANDOM_BEATS = 630;

    typedef struct packed {
        logic       found;
        logic [8:0] total;
        logic [8:0] uniq;
        logic [63:0] last;
        logic [8:0] tally;
        logic [8:0] occ;
    } answer_t;

    class window_tracker_sb;
        typedef struct {
            logic [63:0] ep;
            logic [63:0] fp;
        } sample_t;
        typedef struct {
            int unsigned total;
            int unsigned uniq;
            logic [63:0] last;
        } peer_t;

        sample_t ring[WINDOW_DEPTH];
        int unsigned ring_head;
        int unsigned ring_fill;
        int unsigned print_cnt[logic [63:0]];
        peer_t peers[logic [63:0]];
        int unsigned pair_cnt[logic [127:0]];
        answer_t pending_answers[int unsigned];
        int unsigned pend_wr;
        int unsigned pend_rd;
        bit failed;

        function int unsigned outstanding();
            return pend_wr - pend_rd;
        endfunction

        function void wipe();
            ring_head = 0;
            ring_fill = 0;
            print_cnt.delete();
            peers.delete();
            pair_cnt.delete();
        endfunction

        function void retire_oldest();
            sample_t s;
            logic [127:0] pk;
            s = ring[ring_head];
            ring_head = (ring_head + 1) % WINDOW_DEPTH;
            ring_fill--;
            pk = {s.ep, s.fp};
            if (print_cnt.exists(s.fp))
            begin
                if (print_cnt[s.fp] > 1) print_cnt[s.fp]--;
                else print_cnt.delete(s.fp);
            end
            if (!peers.exists(s.ep)) return;
            if (peers[s.ep].total > 0) peers[s.ep].total--;
            if (pair_cnt.exists(pk))
            begin
                if (pair_cnt[pk] > 1) pair_cnt[pk]--;
                else
                begin
                    pair_cnt.delete(pk);
                    if (peers[s.ep].uniq > 0) peers[s.ep].uniq--;
                end
            end
            if (peers[s.ep].total == 0) peers.delete(s.ep);
        endfunction

        function void add_sample(logic [63:0] ep, logic [63:0] fp);
            sample_t s;
            peer_t rec;
            logic [127:0] pk;
            if (ep == 0 || fp == 0) return;
            if (ring_fill >= WINDOW_DEPTH) retire_oldest();
            s.ep = ep;
            s.fp = fp;
            ring[(ring_head + ring_fill) % WINDOW_DEPTH] = s;
            ring_fill++;
            if (print_cnt.exists(fp)) print_cnt[fp]++;
            else print_cnt[fp] = 1;
            if (!peers.exists(ep))
            begin
                rec.total = 0;
                rec.uniq = 0;
                rec.last = 0;
                peers[ep] = rec;
            end
            peers[ep].total++;
            peers[ep].last = fp;
            pk = {ep, fp};
            if (pair_cnt.exists(pk)) pair_cnt[pk]++;
            else
            begin
                pair_cnt[pk] = 1;
                peers[ep].uniq++;
            end
        endfunction

        // one accepted command beat -> one expected answer
        function void note_command(swkft_pkg::op_t op, logic [63:0] ep, logic [63:0] fp);
            answer_t a;
            a = '0;
            case (op)
                swkft_pkg::OP_ADD: add_sample(ep, fp);
                swkft_pkg::OP_EP_QUERY:
                    if (ep != 0 && peers.exists(ep))
                    begin
                        a.found = 1'b1;
                        a.total = 9'(peers[ep].total);
                        a.uniq = 9'(peers[ep].uniq);
                        a.last = peers[ep].last;
                    end
                swkft_pkg::OP_FP_QUERY:
                    if (print_cnt.exists(fp)) a.tally = 9'(print_cnt[fp]);
                default: wipe();
            endcase
            a.occ = 9'(ring_fill);
            pending_answers[pend_wr] = a;
            pend_wr++;
        endfunction

        function void cmp(string name, logic [63:0] e, logic [63:0] g);
            if (e !== g)
            begin
                $display("%0t: %s expected %0h got %0h", $realtime, name, e, g);
                failed = 1;
            end
        endfunction

        function void check_answer(answer_t g);
            answer_t e;
            if (pend_rd == pend_wr)
            begin
                $display("%0t: result with nothing pending, got %0h", $realtime, g);
                failed = 1;
                return;
            end
            e = pending_answers[pend_rd];
            pending_answers.delete(pend_rd);
            pend_rd++;
            cmp("found", 64'(e.found), 64'(g.found));
            cmp("endpoint_total", 64'(e.total), 64'(g.total));
            cmp("endpoint_unique", 64'(e.uniq), 64'(g.uniq));
            cmp("last_fingerprint", e.last, g.last);
            cmp("fingerprint_tally", 64'(e.tally), 64'(g.tally));
            cmp("occupancy", 64'(e.occ), 64'(g.occ));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] opcode;
    logic [63:0] endpoint_key;
    logic [63:0] fingerprint;
    logic done;
    logic found;
    logic [8:0] endpoint_total;
    logic [8:0] endpoint_unique;
    logic [63:0] last_fingerprint;
    logic [8:0] fingerprint_tally;
    logic [8:0] occupancy;

    window_tracker_sb sb;
    int unsigned send_idle_pct;
    int unsigned stall_cycles;
    logic [63:0] ep_pool[6];
    logic [63:0] fp_pool[12];

    sliding_window_key_frequency_tracker uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .endpoint_key(endpoint_key),
        .fingerprint(fingerprint),
        .done(done),
        .found(found),
        .endpoint_total(endpoint_total),
        .endpoint_unique(endpoint_unique),
        .last_fingerprint(last_fingerprint),
        .fingerprint_tally(fingerprint_tally),
        .occupancy(occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_answer({found, endpoint_total, endpoint_unique, last_fingerprint,
                             fingerprint_tally, occupancy});
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // holds start until the beat is taken, then idles at random
    task automatic send(swkft_pkg::op_t op, logic [63:0] ep, logic [63:0] fp);
        start <= 1'b1;
        opcode <= op;
        endpoint_key <= ep;
        fingerprint <= fp;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_command(op, ep, fp);
        if ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [63:0] pick_ep();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3) return 64'd0;
        if (r < 82) return ep_pool[$urandom_range(5)];
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_fp();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3) return 64'd0;
        if (r < 82) return fp_pool[$urandom_range(11)];
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        int unsigned r;
        sb = new();
        sb.failed = 0;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = swkft_pkg::OP_ADD;
        endpoint_key = '0;
        fingerprint = '0;
        stall_cycles = 0;
        send_idle_pct = 16;
        foreach (ep_pool[i]) ep_pool[i] = {$urandom, $urandom};
        foreach (fp_pool[i]) fp_pool[i] = {$urandom, $urandom};
        ep_pool[0] = '1;
        fp_pool[0] = '1;
        ep_pool[1] = 64'd1;
        fp_pool[1] = 64'd1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed beats
        send(swkft_pkg::OP_EP_QUERY, 64'd1, 64'd0);
        send(swkft_pkg::OP_FP_QUERY, 64'd0, 64'd0);
        send(swkft_pkg::OP_ADD, 64'd0, 64'd5);
        send(swkft_pkg::OP_ADD, 64'd7, 64'd0);
        send(swkft_pkg::OP_ADD, '1, '1);
        send(swkft_pkg::OP_ADD, '1, 64'd1);
        send(swkft_pkg::OP_ADD, '1, '1);
        send(swkft_pkg::OP_ADD, 64'd1, '1);
        send(swkft_pkg::OP_EP_QUERY, '1, 64'd0);
        send(swkft_pkg::OP_EP_QUERY, 64'd1, '1);
        send(swkft_pkg::OP_EP_QUERY, 64'd0, '1);
        send(swkft_pkg::OP_EP_QUERY, 64'd99, '1);
        send(swkft_pkg::OP_FP_QUERY, 64'd0, '1);
        send(swkft_pkg::OP_FP_QUERY, '1, 64'd1);
        send(swkft_pkg::OP_FP_QUERY, 64'd0, 64'd42);
        drain();
        send(swkft_pkg::OP_CLEAR, '1, '1);
        send(swkft_pkg::OP_EP_QUERY, '1, 64'd0);
        send(swkft_pkg::OP_FP_QUERY, 64'd0, '1);

        // random beats in three idle regimes; adds dominate so the window wraps
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == RANDOM_BEATS / 3) send_idle_pct = 57;
            if (n == 2 * RANDOM_BEATS / 3) send_idle_pct = 0;
            r = $urandom_range(999);
            if (r < 580) send(swkft_pkg::OP_ADD, pick_ep(), pick_fp());
            else if (r < 790) send(swkft_pkg::OP_EP_QUERY, pick_ep(), pick_fp());
            else if (r < 995) send(swkft_pkg::OP_FP_QUERY, pick_ep(), pick_fp());
            else
            begin
                drain();
                send(swkft_pkg::OP_CLEAR, pick_ep(), pick_fp());
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (!sb.failed)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
